@@ hdl/lcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants of the LFU cache policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_pkg;

    // store geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // field widths
    localparam int WORD_W      = 32;
    localparam int USE_W       = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [USE_W-1:0] USE_MAX   = {USE_W{1'b1}};

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] value;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
        logic [USE_W-1:0]  count;
        logic [WORD_W-1:0] stamp;
    } entry_t;

    // handshake between engine and the two queues
    typedef struct packed {
        logic take;
        logic push;
    } eng_ctl_t;

endpackage

`default_nettype wire

@@ hdl/lcp_ram.sv @@
// ----------------------------------------------------------------------------
// lcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/lcp_front.sv @@
// ----------------------------------------------------------------------------
// lcp_front
// Input side: two-deep item queue that accepts and decodes requests.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               operation,
    input  wire logic [31:0]        lookup_key,
    input  wire logic [31:0]        write_value,
    output logic                    item_valid,
    output lcp_pkg::item_t          item,
    input  wire logic               take
);

    lcp_pkg::item_t slot_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           wr;
    logic           rd;
    lcp_pkg::item_t incoming;

    // decode the request into an item
    always_comb
    begin
        incoming.op    = (operation == lcp_pkg::OP_PUT) ? lcp_pkg::OP_PUT : lcp_pkg::OP_GET;
        incoming.key   = lookup_key;
        incoming.value = (operation == lcp_pkg::OP_PUT) ? write_value : '0;
    end

    assign full       = fill_reg[1];
    assign item_valid = (fill_reg != 2'd0);
    assign item       = slot_reg[rptr_reg];
    assign wr         = push && !full;
    assign rd         = take && item_valid;

    // pointer and fill update
    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg;
        if (wr && !rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lcp_outq.sv @@
// ----------------------------------------------------------------------------
// lcp_outq
// Output side: two-deep result queue presented as empty / pop.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_outq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_push,
    input  wire lcp_pkg::result_t res_item,
    output logic                 res_full,
    output logic                 empty,
    input  wire logic            pop,
    output logic                 found,
    output logic [31:0]          read_value
);

    lcp_pkg::result_t slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             wr;
    logic             rd;

    assign res_full   = fill_reg[1];
    assign empty      = (fill_reg == 2'd0);
    assign found      = slot_reg[rptr_reg].found;
    assign read_value = slot_reg[rptr_reg].value;
    assign wr         = res_push && !res_full;
    assign rd         = pop && !empty;

    // pointer and fill update
    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg;
        if (wr && !rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= res_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lcp_engine.sv @@
// ----------------------------------------------------------------------------
// lcp_engine
// Back end: scans the entry store one entry a cycle for the key and the
// eviction victim, then commits the hit update or the insert.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [lcp_pkg::CAP_W-1:0]    capacity,
    input  wire logic                         item_valid,
    input  wire lcp_pkg::item_t               item,
    input  wire logic                         out_full,
    output lcp_pkg::eng_ctl_t                 ctl,
    output lcp_pkg::result_t                  res_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    localparam int IW = lcp_pkg::IDX_W;
    localparam int CW = lcp_pkg::CNT_W;
    localparam int MW = lcp_pkg::CMP_W;
    localparam int WW = lcp_pkg::WORD_W;
    localparam int UW = lcp_pkg::USE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(lcp_pkg::MAX_ENTRIES - 1);

    state_t               state_reg, state_next;
    logic [lcp_pkg::MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [WW-1:0]        clock_reg, clock_next;
    lcp_pkg::item_t       item_reg, item_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pidx_reg, pidx_next;
    logic [CW-1:0]        used_reg, used_next;
    logic                 hit_reg, hit_next;
    logic [IW-1:0]        hidx_reg, hidx_next;
    logic [WW-1:0]        hval_reg, hval_next;
    logic [UW-1:0]        hcnt_reg, hcnt_next;
    logic                 hfree_reg, hfree_next;
    logic [IW-1:0]        fidx_reg, fidx_next;
    logic                 hvic_reg, hvic_next;
    logic [IW-1:0]        vidx_reg, vidx_next;
    logic [UW-1:0]        vcnt_reg, vcnt_next;
    logic [WW-1:0]        vstp_reg, vstp_next;
    lcp_pkg::eng_ctl_t    ctl_reg, ctl_next;
    lcp_pkg::result_t     res_reg, res_next;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    lcp_pkg::entry_t      rd_ent;
    logic [$bits(lcp_pkg::entry_t)-1:0] rd_bits;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    lcp_pkg::entry_t      wr_ent;

    logic                 ent_ok;
    logic                 is_match;
    logic                 is_better;
    logic                 is_free;
    logic [MW-1:0]        cap_x;
    logic [MW-1:0]        eff_cap;
    logic                 at_cap;
    logic [IW-1:0]        slot;

    lcp_ram #(
        .WIDTH ($bits(lcp_pkg::entry_t)),
        .DEPTH (lcp_pkg::MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_ent   = lcp_pkg::entry_t'(rd_bits);
    assign ctl      = ctl_reg;
    assign res_item = res_reg;

    // per-entry evaluation of the word read last cycle
    always_comb
    begin
        ent_ok    = pend_reg && valid_reg[pidx_reg];
        is_match  = ent_ok && !hit_reg && (rd_ent.key == item_reg.key);
        is_better = ent_ok && (!hvic_reg || (rd_ent.count < vcnt_reg) ||
                    ((rd_ent.count == vcnt_reg) && (rd_ent.stamp < vstp_reg)));
        is_free   = pend_reg && !valid_reg[pidx_reg] && !hfree_reg;
    end

    // effective capacity and insert slot
    always_comb
    begin
        cap_x = MW'(capacity);
        if (cap_x == '0)
        begin
            eff_cap = MW'(1);
        end
        else if (cap_x > MW'(lcp_pkg::MAX_ENTRIES))
        begin
            eff_cap = MW'(lcp_pkg::MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_x;
        end
        at_cap = (MW'(used_reg) >= eff_cap);
        if (at_cap && hvic_reg)
        begin
            slot = vidx_reg;
        end
        else if (hfree_reg)
        begin
            slot = fidx_reg;
        end
        else
        begin
            slot = vidx_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        clock_next = clock_reg;
        item_next  = item_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        used_next  = used_reg;
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        hval_next  = hval_reg;
        hcnt_next  = hcnt_reg;
        hfree_next = hfree_reg;
        fidx_next  = fidx_reg;
        hvic_next  = hvic_reg;
        vidx_next  = vidx_reg;
        vcnt_next  = vcnt_reg;
        vstp_next  = vstp_reg;
        ctl_next   = '0;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = slot;
        wr_ent     = '0;

        // fold in the entry that arrived from the store
        if (ent_ok)
        begin
            used_next = used_reg + CW'(1);
        end
        if (is_match)
        begin
            hit_next  = 1'b1;
            hidx_next = pidx_reg;
            hval_next = rd_ent.value;
            hcnt_next = rd_ent.count;
        end
        if (is_better)
        begin
            hvic_next = 1'b1;
            vidx_next = pidx_reg;
            vcnt_next = rd_ent.count;
            vstp_next = rd_ent.stamp;
        end
        if (is_free)
        begin
            hfree_next = 1'b1;
            fidx_next  = pidx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // wait for a pending result push to land so out_full is current
                if (item_valid && !out_full && !ctl_reg.push)
                begin
                    ctl_next.take = 1'b1;
                    item_next     = item;
                    idx_next      = '0;
                    used_next     = '0;
                    hit_next      = 1'b0;
                    hfree_next    = 1'b0;
                    hvic_next     = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en     = 1'b1;
                pend_next = 1'b1;
                pidx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl_next.push  = 1'b1;
                res_next.found = hit_reg;
                res_next.value = '0;
                if (hit_reg)
                begin
                    // hit: raise count, refresh stamp
                    wr_en         = 1'b1;
                    wr_addr       = hidx_reg;
                    wr_ent.key    = item_reg.key;
                    wr_ent.value  = (item_reg.op == lcp_pkg::OP_PUT) ? item_reg.value
                                                                     : hval_reg;
                    wr_ent.count  = (hcnt_reg == lcp_pkg::USE_MAX) ? hcnt_reg
                                                                   : hcnt_reg + UW'(1);
                    wr_ent.stamp  = clock_reg;
                    clock_next    = clock_reg + WW'(1);
                    if (item_reg.op == lcp_pkg::OP_GET)
                    begin
                        res_next.value = hval_reg;
                    end
                end
                else if (item_reg.op == lcp_pkg::OP_PUT)
                begin
                    // miss on put: insert, evicting if needed
                    wr_en             = 1'b1;
                    wr_addr           = slot;
                    wr_ent.key        = item_reg.key;
                    wr_ent.value      = item_reg.value;
                    wr_ent.count      = UW'(1);
                    wr_ent.stamp      = clock_reg;
                    clock_next        = clock_reg + WW'(1);
                    valid_next[slot]  = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            clock_reg <= '0;
            pend_reg  <= 1'b0;
            ctl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            clock_reg <= clock_next;
            pend_reg  <= pend_next;
            ctl_reg   <= ctl_next;
        end
    end

    // scan bookkeeping and payload
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        pidx_reg  <= pidx_next;
        used_reg  <= used_next;
        hit_reg   <= hit_next;
        hidx_reg  <= hidx_next;
        hval_reg  <= hval_next;
        hcnt_reg  <= hcnt_next;
        hfree_reg <= hfree_next;
        fidx_reg  <= fidx_next;
        hvic_reg  <= hvic_next;
        vidx_reg  <= vidx_next;
        vcnt_reg  <= vcnt_next;
        vstp_reg  <= vstp_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

@@ hdl/lfu_cache_policy.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_policy
// Key-value store with least-frequently-used replacement, LRU tie break.
// ----------------------------------------------------------------------------
// Items enter a two-deep request queue (push/full) and results leave a
// two-deep result queue (empty/pop), one result per item in order. The
// engine handles one item at a time: it reads the entry store once per
// entry, one entry a cycle from its single read port, then commits and
// queues the result, and it takes no new item until that result is
// queued. The store is empty after reset with no clearing pass; capacity
// is written through cfg_write / cfg_data, and the user must write it only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module lfu_cache_policy (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [31:0] lookup_key,
    input  wire logic [31:0] write_value,
    output logic             empty,
    input  wire logic        pop,
    output logic             found,
    output logic [31:0]      read_value
);

    logic [lcp_pkg::CAP_W-1:0] cap_reg;
    logic                      item_valid;
    lcp_pkg::item_t            item;
    lcp_pkg::eng_ctl_t         ctl;
    lcp_pkg::result_t          res_item;
    logic                      res_full;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lcp_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= cfg_data;
        end
    end

    lcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .item_valid  (item_valid),
        .item        (item),
        .take        (ctl.take)
    );

    lcp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (cap_reg),
        .item_valid (item_valid),
        .item       (item),
        .out_full   (res_full),
        .ctl        (ctl),
        .res_item   (res_item)
    );

    lcp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (ctl.push),
        .res_item   (res_item),
        .res_full   (res_full),
        .empty      (empty),
        .pop        (pop),
        .found      (found),
        .read_value (read_value)
    );

    // engine never queues a result without room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !res_full)
        else $error("result pushed into full queue");

    // engine takes only a waiting item
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> item_valid)
        else $error("item taken from empty queue");

    // take and push never coincide
    a_take_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.take && ctl.push))
        else $error("engine overlapped two items");

endmodule

`default_nettype wire
